// ----- rtl/core/bbpq_pkg.sv -----
// Package: shared constants and field widths of the byte-budget priority queue.
`default_nettype none
package bbpq_pkg;
	localparam int ENTRIES  = 16;
	localparam int SLOT_W   = $clog2(ENTRIES);
	localparam int LINK_W   = SLOT_W + 1;
	localparam int COUNT_W  = $clog2(ENTRIES + 1);
	localparam int FREED_W  = 16 + $clog2(ENTRIES) + 1;
	localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(ENTRIES);

	localparam logic [2:0] FUNC_ADD   = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_NEXT  = 3'd2;
	localparam logic [2:0] FUNC_BACK  = 3'd3;
	localparam logic [2:0] FUNC_REM   = 3'd4;

	localparam logic [7:0] REG_BUDGET  = 8'd0;
	localparam logic [7:0] REG_BACKOFF = 8'd1;
endpackage
`default_nettype wire

// ----- rtl/core/byte_budget_priority_queue_unit.sv -----
// Top level: byte-budget priority queue with tail eviction and an iterator.
`default_nettype none
// Keeps up to ENTRIES messages (handle, bytes, priority, backoff) in a doubly
// linked list of slots, highest priority first and first-in first-out among
// equal priorities, under a total byte budget. One word in gives one word out.
// A small sequencer runs every operation through one slot read port and one
// slot write port, so the block takes one word at a time. An add inspects
// tail entries for eviction, evicts those that must go and walks the entries
// to find the insertion point; an oversized add is rejected, and a backoff
// that passes the limit removes its entry. A finished word waits in the
// output register while the next input word is taken. Configuration writes
// are taken in any cycle and should be made only while the block is idle.
module byte_budget_priority_queue_unit import bbpq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// func[2:0], msg_handle[18:3], msg_bytes[34:19], msg_priority[50:35], zero fill
	input  wire logic [55:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// ok[0], got_handle[16:1], got_bytes[32:17], got_priority[48:33],
	// got_backoff[56:49], top_priority[72:57], bytes_used[88:73],
	// entry_count[93:89], zero fill
	output logic [95:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACHK  = 4'd1;
	localparam logic [3:0] ST_AEV   = 4'd2;
	localparam logic [3:0] ST_AUNL  = 4'd3;
	localparam logic [3:0] ST_AFREE = 4'd4;
	localparam logic [3:0] ST_APOS  = 4'd5;
	localparam logic [3:0] ST_AW1   = 4'd6;
	localparam logic [3:0] ST_AW2   = 4'd7;
	localparam logic [3:0] ST_AW3   = 4'd8;
	localparam logic [3:0] ST_U1    = 4'd9;
	localparam logic [3:0] ST_U2    = 4'd10;
	localparam logic [3:0] ST_NEXT  = 4'd11;
	localparam logic [3:0] ST_BACK  = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;

	// slot storage: one read address and one write address per cycle
	logic [15:0]       slot_handle_q   [ENTRIES];
	logic [15:0]       slot_bytes_q    [ENTRIES];
	logic [15:0]       slot_priority_q [ENTRIES];
	logic [7:0]        slot_backoff_q  [ENTRIES];
	logic [LINK_W-1:0] link_fwd_q      [ENTRIES];
	logic [LINK_W-1:0] link_back_q     [ENTRIES];
	logic [ENTRIES-1:0] slot_used_q;

	logic [3:0]         state_q;
	logic [2:0]         func_q;
	logic [15:0]        handle_q, bytes_q, prio_q;
	logic [15:0]        budget_q;
	logic [7:0]         limit_q;
	logic [LINK_W-1:0]  head_q, tail_q, cur_q, next_q;
	logic [LINK_W-1:0]  s_q, f_q, pos_q, prev_q, lf_q, lb_q;
	logic [15:0]        total_q;
	logic [COUNT_W-1:0] count_q, k_q;
	logic [FREED_W-1:0] freed_q;
	logic [15:0]        ubytes_q;
	logic               ok_q;
	logic [15:0]        gh_q, gb_q, gp_q;
	logic [7:0]         gk_q;

	// read port
	logic [LINK_W-1:0] rd_addr;
	logic [SLOT_W-1:0] ra;
	logic              rd_ok;
	logic [15:0]       rd_bytes, rd_prio;
	logic [7:0]        rd_bo;
	logic [LINK_W-1:0] rd_fwd, rd_back;

	// write port
	logic [SLOT_W-1:0] wa;
	logic              we_rec, we_fwd, we_back, we_bo;
	logic [LINK_W-1:0] wd_fwd, wd_back;
	logic [7:0]        wd_bo;

	logic              need_room;
	logic [7:0]        bo_inc;
	logic [LINK_W-1:0] free_slot;

	always_comb begin
		case (state_q)
			ST_AEV, ST_U1: rd_addr = s_q;
			ST_APOS:       rd_addr = pos_q;
			ST_NEXT:       rd_addr = next_q;
			ST_BACK:       rd_addr = cur_q;
			default:       rd_addr = head_q;
		endcase
	end
	assign ra       = rd_addr[SLOT_W-1:0];
	assign rd_ok    = !rd_addr[LINK_W-1];
	assign rd_bytes = slot_bytes_q[ra];
	assign rd_prio  = slot_priority_q[ra];
	assign rd_bo    = slot_backoff_q[ra];
	assign rd_fwd   = link_fwd_q[ra];
	assign rd_back  = link_back_q[ra];

	// room is short if the bytes overflow the budget or no slot stays free
	assign need_room = (FREED_W'(total_q) + FREED_W'(bytes_q)) >
	                   (FREED_W'(budget_q) + freed_q) ||
	                   (count_q - k_q) >= COUNT_W'(ENTRIES);
	assign bo_inc = (rd_bo == 8'hFF) ? 8'hFF : rd_bo + 8'd1;

	// lowest free slot
	always_comb begin
		free_slot = NONE_SLOT;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) free_slot = LINK_W'(i);
		end
	end

	always_comb begin
		wa      = s_q[SLOT_W-1:0];
		we_rec  = 1'b0;
		we_fwd  = 1'b0;
		we_back = 1'b0;
		we_bo   = 1'b0;
		wd_fwd  = pos_q;
		wd_back = prev_q;
		wd_bo   = 8'd0;
		case (state_q)
			ST_AW1: begin
				wa     = f_q[SLOT_W-1:0];
				we_rec = 1'b1;
			end
			ST_AW2: begin
				wa     = prev_q[SLOT_W-1:0];
				we_fwd = !prev_q[LINK_W-1];
				wd_fwd = f_q;
			end
			ST_AW3: begin
				wa      = pos_q[SLOT_W-1:0];
				we_back = !pos_q[LINK_W-1];
				wd_back = f_q;
			end
			ST_U1: begin
				// point the predecessor past the leaving slot
				wa     = rd_back[SLOT_W-1:0];
				we_fwd = !rd_back[LINK_W-1];
				wd_fwd = rd_fwd;
			end
			ST_U2: begin
				wa      = lf_q[SLOT_W-1:0];
				we_back = !lf_q[LINK_W-1];
				wd_back = lb_q;
			end
			ST_BACK: begin
				wa    = cur_q[SLOT_W-1:0];
				we_bo = !cur_q[LINK_W-1];
				wd_bo = bo_inc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_rec) begin
			slot_handle_q[wa]   <= handle_q;
			slot_bytes_q[wa]    <= bytes_q;
			slot_priority_q[wa] <= prio_q;
		end
		if (we_rec || we_bo) slot_backoff_q[wa] <= wd_bo;
		if (we_rec || we_fwd) link_fwd_q[wa] <= wd_fwd;
		if (we_rec || we_back) link_back_q[wa] <= wd_back;
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_used_q <= '0;
			head_q      <= NONE_SLOT;
			tail_q      <= NONE_SLOT;
			cur_q       <= NONE_SLOT;
			next_q      <= NONE_SLOT;
			total_q     <= '0;
			count_q     <= '0;
			budget_q    <= '0;
			limit_q     <= 8'd2;
			m_tvalid    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BUDGET) budget_q <= cfg_data;
				else if (cfg_index == REG_BACKOFF) limit_q <= cfg_data[7:0];
			end
			// load a finished word, else drop the one just taken
			if (state_q == ST_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ok_q <= 1'b0;
						gh_q <= '0;
						gb_q <= '0;
						gp_q <= '0;
						gk_q <= '0;
						case (s_tdata[2:0])
							FUNC_ADD:   state_q <= ST_ACHK;
							FUNC_START: begin
								next_q  <= head_q;
								cur_q   <= NONE_SLOT;
								state_q <= ST_FIN;
							end
							FUNC_NEXT:  state_q <= ST_NEXT;
							FUNC_BACK:  state_q <= cur_q[LINK_W-1] ? ST_FIN : ST_BACK;
							FUNC_REM: begin
								s_q     <= cur_q;
								state_q <= cur_q[LINK_W-1] ? ST_FIN : ST_U1;
							end
							default:    state_q <= ST_FIN;
						endcase
					end
				end
				ST_ACHK: begin
					freed_q <= '0;
					k_q     <= '0;
					s_q     <= tail_q;
					state_q <= (bytes_q > budget_q) ? ST_FIN : ST_AEV;
				end
				ST_AEV: begin
					// walk lower-priority tail entries until the word fits
					if (rd_ok && rd_prio < prio_q && need_room) begin
						freed_q <= freed_q + FREED_W'(rd_bytes);
						k_q     <= k_q + COUNT_W'(1);
						s_q     <= rd_back;
					end else begin
						state_q <= need_room ? ST_FIN : ST_AUNL;
					end
				end
				ST_AUNL: begin
					if (k_q != '0 && !tail_q[LINK_W-1]) begin
						k_q     <= k_q - COUNT_W'(1);
						s_q     <= tail_q;
						state_q <= ST_U1;
					end else begin
						state_q <= ST_AFREE;
					end
				end
				ST_AFREE: begin
					f_q     <= free_slot;
					pos_q   <= head_q;
					state_q <= free_slot[LINK_W-1] ? ST_FIN : ST_APOS;
				end
				ST_APOS: begin
					if (rd_ok && rd_prio >= prio_q) begin
						pos_q <= rd_fwd;
					end else begin
						prev_q  <= rd_ok ? rd_back : tail_q;
						state_q <= ST_AW1;
					end
				end
				ST_AW1: begin
					slot_used_q[f_q[SLOT_W-1:0]] <= 1'b1;
					state_q <= ST_AW2;
				end
				ST_AW2: begin
					if (prev_q[LINK_W-1]) head_q <= f_q;
					state_q <= ST_AW3;
				end
				ST_AW3: begin
					if (pos_q[LINK_W-1]) tail_q <= f_q;
					total_q <= total_q + bytes_q;
					count_q <= count_q + COUNT_W'(1);
					ok_q    <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_U1: begin
					if (rd_back[LINK_W-1]) head_q <= rd_fwd;
					lf_q     <= rd_fwd;
					lb_q     <= rd_back;
					ubytes_q <= rd_bytes;
					state_q  <= ST_U2;
				end
				ST_U2: begin
					if (lf_q[LINK_W-1]) tail_q <= lb_q;
					total_q <= (total_q >= ubytes_q) ? total_q - ubytes_q : '0;
					if (count_q != '0) count_q <= count_q - COUNT_W'(1);
					slot_used_q[s_q[SLOT_W-1:0]] <= 1'b0;
					if (cur_q == s_q) cur_q <= NONE_SLOT;
					if (next_q == s_q) next_q <= lf_q;
					state_q <= (func_q == FUNC_ADD) ? ST_AUNL : ST_FIN;
				end
				ST_NEXT: begin
					cur_q <= NONE_SLOT;
					if (rd_ok) begin
						ok_q   <= 1'b1;
						gh_q   <= slot_handle_q[ra];
						gb_q   <= rd_bytes;
						gp_q   <= rd_prio;
						gk_q   <= rd_bo;
						cur_q  <= next_q;
						next_q <= rd_fwd;
					end
					state_q <= ST_FIN;
				end
				ST_BACK: begin
					s_q <= cur_q;
					if (bo_inc > limit_q) begin
						state_q <= ST_U1;
					end else begin
						ok_q    <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!m_tvalid || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture and result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			func_q   <= s_tdata[2:0];
			handle_q <= s_tdata[18:3];
			bytes_q  <= s_tdata[34:19];
			prio_q   <= s_tdata[50:35];
		end
		if (state_q == ST_FIN && (!m_tvalid || m_tready)) begin
			m_tdata <= {2'b00, count_q, total_q, rd_ok ? rd_prio : 16'd0,
			            gk_q, gp_q, gb_q, gh_q, ok_q};
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(ENTRIES))
		else $error("entry count above capacity");
	a_used_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> $countones(slot_used_q) == int'(count_q))
		else $error("slot use bits disagree with entry count");
	a_empty_links: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q == '0) |-> (head_q == NONE_SLOT && tail_q == NONE_SLOT))
		else $error("empty queue with a head or tail");
endmodule
`default_nettype wire
